### hdl/wmss_pkg.sv
// ----------------------------------------------------------------------------
// wmss_pkg: weight matrix site scanner shared types and constants
// Payload structs, configuration register codes and sizing constants.
// ----------------------------------------------------------------------------
package wmss_pkg;

  localparam int MAX_WIDTH      = 32;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS     = 6;
  localparam int SCORE_BITS     = 16;
  localparam int POS_BITS       = 16;
  localparam int SEQ_BITS       = 16;
  localparam int SCORE_OUT_BITS = 20;
  localparam int GRP_SIZE       = 4;
  localparam int NUM_GRPS       = MAX_WIDTH / GRP_SIZE;
  localparam int GRP_BITS       = SCORE_BITS + 2;
  localparam int SUM_BITS       = GRP_BITS + 3;
  localparam int NUM_BASES      = 4;
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(8);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_LEN = 1'b0,
    CFG_FWD_ONLY   = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_SCAN = 1'b1
  } item_mode_e;

  typedef struct packed {
    logic                   mode;
    logic                   load_strand;
    logic [4:0]             load_column;
    logic [1:0]             load_base;
    logic signed [15:0]     load_value;
    logic [2:0]             base_code;
    logic                   end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sequence_index;
    logic [15:0] site_position;
    logic [19:0] site_score;
    logic        forward_strand;
    logic        last_of_run;
  } out_item_t;

  // Per-item control carried down the scoring pipeline
  typedef struct packed {
    logic                emit;
    logic                single;
    logic [SEQ_BITS-1:0] seq;
    logic [POS_BITS-1:0] pos;
  } site_meta_t;

endpackage

### hdl/weight_matrix_site_scanner_unit.sv
// Sites of an item pass the input, B, C and D registers on their way to the output register.
// Throughput: one item per cycle while the output is not stalled; an item with hits on
// both strands stalls the input until both sites are sent, since one result register drives the output.
// Scoring path: input register, column lookup, 4-wide group adders, final adder.
// Reset: clears weights, history, run length, position, sequence count and
// all pipeline valid flags; window width returns to 8 and forward-only mode off.
// ----------------------------------------------------------------------------
// weight_matrix_site_scanner_unit: two-strand weight matrix site scanner
// Loads signed Q8.8 weight matrices and scores every all-valid window of
// the configured width against forward and reverse matrices.
// ----------------------------------------------------------------------------
module weight_matrix_site_scanner_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  wmss_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wmss_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [wmss_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [wmss_pkg::WIDTH_BITS-1:0]     cfg_data_i
);
  import wmss_pkg::*;

  // configuration
  logic [WIDTH_BITS-1:0] width_q;
  logic                  single_q;

  // matrices and scan state
  logic signed [SCORE_BITS-1:0] fwd_w_q [MAX_WIDTH][NUM_BASES];
  logic signed [SCORE_BITS-1:0] rev_w_q [MAX_WIDTH][NUM_BASES];
  logic [1:0]                   hist_q  [MAX_WIDTH];
  logic [1:0]                   hist_d  [MAX_WIDTH];
  logic [WIDTH_BITS-1:0]        run_q, run_d;
  logic [POS_BITS-1:0]          pos_q;
  logic [SEQ_BITS-1:0]          seq_q;

  // pipeline
  logic                         adv;
  logic                         in_vld_q;
  in_item_t                     in_q;
  logic                         b_vld_q, c_vld_q, d_vld_q;
  site_meta_t                   a_meta, b_meta_q, c_meta_q, d_meta_q;
  logic signed [SCORE_BITS-1:0] a_fterm [MAX_WIDTH];
  logic signed [SCORE_BITS-1:0] a_rterm [MAX_WIDTH];
  logic signed [SCORE_BITS-1:0] b_fterm_q [MAX_WIDTH];
  logic signed [SCORE_BITS-1:0] b_rterm_q [MAX_WIDTH];
  logic signed [GRP_BITS-1:0]   c_fgrp_d [NUM_GRPS];
  logic signed [GRP_BITS-1:0]   c_rgrp_d [NUM_GRPS];
  logic signed [GRP_BITS-1:0]   c_fgrp_q [NUM_GRPS];
  logic signed [GRP_BITS-1:0]   c_rgrp_q [NUM_GRPS];
  logic signed [SUM_BITS-1:0]   d_fsum_d, d_rsum_d;
  logic signed [SUM_BITS-1:0]   d_fsum_q, d_rsum_q;

  // output register
  logic                         of_q, or_q;
  logic [SEQ_BITS-1:0]          o_seq_q;
  logic [POS_BITS-1:0]          o_pos_q;
  logic [SCORE_OUT_BITS-1:0]    o_fscore_q, o_rscore_q;

  logic                  a_fire, a_scan, a_ok, a_emit;
  logic [WIDTH_BITS-1:0] w_act;
  logic [WIDTH_BITS-1:0] tap;
  logic [1:0]            col_base;
  logic                  d_hit_f, d_hit_r;
  logic                  out_xfer;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      single_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_WINDOW_LEN: width_q  <= cfg_data_i;
        CFG_FWD_ONLY:   single_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_act = WIDTH_BITS'(1);
    end else if (width_q > WIDTH_BITS'(MAX_WIDTH)) begin
      w_act = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      w_act = width_q;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the whole pipeline advances when the output register frees up
  // --------------------------------------------------------------------------
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign adv        = !(of_q || or_q) || (out_xfer && !(of_q && or_q));
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      d_vld_q  <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_valid_i;
      b_vld_q  <= in_vld_q && a_scan;
      c_vld_q  <= b_vld_q;
      d_vld_q  <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: state update and column lookup
  // --------------------------------------------------------------------------
  assign a_scan = (item_mode_e'(in_q.mode) == MODE_SCAN);
  assign a_fire = adv && in_vld_q;
  assign a_ok   = !in_q.base_code[2];

  always_comb begin
    hist_d[0] = in_q.base_code[1:0];
    for (int i = 1; i < MAX_WIDTH; i++) begin
      hist_d[i] = hist_q[i-1];
    end
  end

  always_comb begin
    if (!a_ok) begin
      run_d = '0;
    end else if (run_q < WIDTH_BITS'(MAX_WIDTH)) begin
      run_d = run_q + WIDTH_BITS'(1);
    end else begin
      run_d = run_q;
    end
  end

  assign a_emit = a_ok && (run_d >= w_act);

  always_comb begin
    a_meta.emit   = a_emit;
    a_meta.single = single_q;
    a_meta.seq    = seq_q;
    a_meta.pos    = pos_q - POS_BITS'(w_act - WIDTH_BITS'(1));
  end

  // Column i sees the base that entered w-1-i bases ago
  always_comb begin
    tap      = '0;
    col_base = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      tap      = w_act - WIDTH_BITS'(1) - WIDTH_BITS'(i);
      col_base = hist_d[tap[COL_BITS-1:0]];
      if (WIDTH_BITS'(i) < w_act) begin
        a_fterm[i] = fwd_w_q[i][col_base];
        a_rterm[i] = rev_w_q[i][col_base];
      end else begin
        a_fterm[i] = '0;
        a_rterm[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        hist_q[i] <= '0;
        for (int j = 0; j < NUM_BASES; j++) begin
          fwd_w_q[i][j] <= '0;
          rev_w_q[i][j] <= '0;
        end
      end
      run_q <= '0;
      pos_q <= '0;
      seq_q <= '0;
    end else if (a_fire) begin
      if (!a_scan) begin
        if (in_q.load_strand) begin
          rev_w_q[in_q.load_column][in_q.load_base] <= in_q.load_value;
        end else begin
          fwd_w_q[in_q.load_column][in_q.load_base] <= in_q.load_value;
        end
      end else begin
        hist_q <= hist_d;
        if (in_q.end_of_sequence) begin
          run_q <= '0;
          pos_q <= '0;
          if (seq_q != '1) begin
            seq_q <= seq_q + SEQ_BITS'(1);
          end
        end else begin
          run_q <= run_d;
          if (pos_q != '1) begin
            pos_q <= pos_q + POS_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_meta_q  <= a_meta;
      b_fterm_q <= a_fterm;
      b_rterm_q <= a_rterm;
    end
  end

  // --------------------------------------------------------------------------
  // Stages C and D: registered adder tree
  // --------------------------------------------------------------------------
  always_comb begin
    for (int g = 0; g < NUM_GRPS; g++) begin
      c_fgrp_d[g] = '0;
      c_rgrp_d[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        c_fgrp_d[g] = c_fgrp_d[g] + GRP_BITS'(b_fterm_q[g*GRP_SIZE+k]);
        c_rgrp_d[g] = c_rgrp_d[g] + GRP_BITS'(b_rterm_q[g*GRP_SIZE+k]);
      end
    end
  end

  always_comb begin
    d_fsum_d = '0;
    d_rsum_d = '0;
    for (int g = 0; g < NUM_GRPS; g++) begin
      d_fsum_d = d_fsum_d + SUM_BITS'(c_fgrp_q[g]);
      d_rsum_d = d_rsum_d + SUM_BITS'(c_rgrp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_meta_q <= b_meta_q;
      c_fgrp_q <= c_fgrp_d;
      c_rgrp_q <= c_rgrp_d;
      d_meta_q <= c_meta_q;
      d_fsum_q <= d_fsum_d;
      d_rsum_q <= d_rsum_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: forward site first, then reverse site
  // --------------------------------------------------------------------------
  assign d_hit_f = d_vld_q && d_meta_q.emit && !d_fsum_q[SUM_BITS-1];
  assign d_hit_r = d_vld_q && d_meta_q.emit && !d_meta_q.single && !d_rsum_q[SUM_BITS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_q <= 1'b0;
      or_q <= 1'b0;
    end else if (adv) begin
      of_q <= d_hit_f;
      or_q <= d_hit_r;
    end else if (out_xfer) begin
      // drop the site just sent, keep the other one
      if (of_q) begin
        of_q <= 1'b0;
      end else begin
        or_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_seq_q    <= d_meta_q.seq;
      o_pos_q    <= d_meta_q.pos;
      o_fscore_q <= d_fsum_q[SCORE_OUT_BITS-1:0];
      o_rscore_q <= d_rsum_q[SCORE_OUT_BITS-1:0];
    end
  end

  assign out_valid_o                = of_q || or_q;
  assign out_data_o.sequence_index  = o_seq_q;
  assign out_data_o.site_position   = o_pos_q;
  assign out_data_o.site_score      = of_q ? o_fscore_q : o_rscore_q;
  assign out_data_o.forward_strand  = of_q;
  assign out_data_o.last_of_run     = !(of_q && or_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!out_valid_o || !out_stall_i))
    else $error("input accepted while output register still full");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= WIDTH_BITS'(MAX_WIDTH))
    else $error("valid run length beyond maximum width");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (of_q && or_q && out_xfer) |=> (or_q && !of_q))
    else $error("reverse site lost after forward transfer");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.forward_strand && !out_data_o.last_of_run) |-> or_q)
    else $error("forward site not last without pending reverse site");

  a_site_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (d_hit_f || d_hit_r)) |-> d_vld_q)
    else $error("site emitted from empty pipeline slot");

endmodule
